// File: design/vsa_pkg.sv
// Shared types and constants for the voice slot allocator.
`default_nettype none

package vsa_pkg;

  // Port field widths
  localparam int KIND_W = 3;
  localparam int SLOT_W = 7;
  localparam int ID_W   = 16;
  localparam int PRIO_W = 3;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Input kind codes
  localparam logic [KIND_W-1:0] KIND_ALLOC     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET_PRIO  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FREE_SLOT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FREE_ID   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REPLACE   = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ALLOC,
    OP_SET_PRIO,
    OP_FREE_SLOT,
    OP_FREE_ID,
    OP_REPLACE
  } vsa_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RDSLOT,
    ST_EXEC
  } vsa_state_e;

  typedef struct packed {
    vsa_op_e           op;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   voice_id;
    logic [ID_W-1:0]   new_voice_id;
    logic [PRIO_W-1:0] priority_req;
  } vsa_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] result_slot;
    logic              found;
    logic              stolen;
    logic [ID_W-1:0]   evicted_id;
  } vsa_res_t;

endpackage

`default_nettype wire

// File: design/vsa_front.sv
// Front end: accepts items, decodes them into commands and queues them.
`default_nettype none

module vsa_front import vsa_pkg::*; #(
  parameter int NUM_VOICES = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [SLOT_W-1:0] slot_i,
  input  wire logic [ID_W-1:0]   voice_id_i,
  input  wire logic [ID_W-1:0]   new_voice_id_i,
  input  wire logic [PRIO_W-1:0] priority_req_i,
  output logic                   cmd_valid_o,
  output vsa_cmd_t               cmd_o,
  input  wire logic              cmd_ready_i
);

  vsa_op_e           op;
  logic              slot_ok;
  vsa_cmd_t          cmd_in;
  vsa_cmd_t          q_mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  // slot ops on an index past the table fall through as no-ops
  assign slot_ok = (32'(slot_i) < 32'(NUM_VOICES));

  always_comb begin
    op = OP_NOP;
    case (kind_i)
      KIND_ALLOC:     op = OP_ALLOC;
      KIND_SET_PRIO:  op = slot_ok ? OP_SET_PRIO : OP_NOP;
      KIND_FREE_SLOT: op = slot_ok ? OP_FREE_SLOT : OP_NOP;
      KIND_FREE_ID:   op = OP_FREE_ID;
      KIND_REPLACE:   op = OP_REPLACE;
      default:        op = OP_NOP;
    endcase
  end

  always_comb begin
    cmd_in.op           = op;
    cmd_in.slot         = slot_i;
    cmd_in.voice_id     = voice_id_i;
    cmd_in.new_voice_id = new_voice_id_i;
    cmd_in.priority_req = priority_req_i;
  end

  assign in_ready_o  = (cnt_q != QCNT_W'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// File: design/vsa_back.sv
// Back end: slot table memory, scan sequencer and result register.
`default_nettype none

module vsa_back import vsa_pkg::*; #(
  parameter int NUM_VOICES = 128,
  parameter int ID_BITS    = 16,
  parameter int PRIO_BITS  = 3
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_valid_i,
  input  wire vsa_cmd_t cmd_i,
  output logic          cmd_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output vsa_res_t      res_o
);

  localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int ENT_W = 1 + PRIO_BITS + ID_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

  // table entry: {valid, priority, id}
  logic [ENT_W-1:0]     mem_q [NUM_VOICES];
  logic [ENT_W-1:0]     rd_data_q;
  logic [IDX_W-1:0]     rd_addr, wr_addr;
  logic [ENT_W-1:0]     wr_data;
  logic                 we;

  vsa_state_e           state_q, state_d;
  logic [IDX_W-1:0]     iss_q, iss_d;
  logic                 dv_q, dv_d;
  logic [IDX_W-1:0]     didx_q;
  vsa_cmd_t             cmd_q;
  logic                 start, load;

  logic                 emp_hit_q, match_hit_q;
  logic [IDX_W-1:0]     emp_idx_q, min_idx_q, match_idx_q;
  logic [PRIO_BITS-1:0] min_prio_q;
  logic [ID_BITS-1:0]   min_id_q;

  logic                 out_valid_q;
  vsa_res_t             res_q, res_d;

  logic                 ent_valid;
  logic [PRIO_BITS-1:0] ent_prio;
  logic [ID_BITS-1:0]   ent_id;
  logic [ID_BITS-1:0]   vid_m, nid_m;
  logic [PRIO_BITS-1:0] prio_m;
  logic                 prio_live;
  logic [IDX_W-1:0]     slot_idx, pick;

  assign ent_valid = rd_data_q[ENT_W-1];
  assign ent_prio  = rd_data_q[ID_BITS +: PRIO_BITS];
  assign ent_id    = rd_data_q[ID_BITS-1:0];

  assign vid_m     = ID_BITS'(cmd_q.voice_id);
  assign nid_m     = ID_BITS'(cmd_q.new_voice_id);
  assign prio_m    = PRIO_BITS'(cmd_q.priority_req);
  assign prio_live = (prio_m != '0);
  assign slot_idx  = IDX_W'(cmd_q.slot);
  assign pick      = emp_hit_q ? emp_idx_q : min_idx_q;

  assign start       = (state_q == ST_IDLE) && cmd_valid_i;
  assign cmd_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    iss_d   = iss_q;
    dv_d    = 1'b0;
    rd_addr = slot_idx;
    we      = 1'b0;
    wr_addr = slot_idx;
    wr_data = '0;
    load    = 1'b0;
    res_d   = '0;
    case (state_q)
      ST_CLEAR: begin
        we      = 1'b1;
        wr_addr = iss_q;
        if (iss_q == LAST_IDX) begin
          iss_d   = '0;
          state_d = ST_IDLE;
        end else begin
          iss_d = iss_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_ALLOC, OP_FREE_ID, OP_REPLACE: state_d = ST_SCAN;
            OP_SET_PRIO, OP_FREE_SLOT:        state_d = ST_RDSLOT;
            default:                          state_d = ST_EXEC;
          endcase
        end
      end
      ST_SCAN: begin
        rd_addr = iss_q;
        dv_d    = 1'b1;
        if (iss_q == LAST_IDX) begin
          iss_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          iss_d = iss_q + 1'b1;
        end
      end
      ST_DRAIN:  state_d = ST_EXEC;
      ST_RDSLOT: state_d = ST_EXEC;
      ST_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = ST_IDLE;
          case (cmd_q.op)
            OP_ALLOC: begin
              we                = 1'b1;
              wr_addr           = pick;
              wr_data           = {prio_live, prio_m, nid_m};
              res_d.result_slot = SLOT_W'(pick);
              res_d.found       = 1'b1;
              res_d.stolen      = !emp_hit_q;
              res_d.evicted_id  = emp_hit_q ? '0 : ID_W'(min_id_q);
            end
            OP_SET_PRIO: begin
              if (ent_valid) begin
                we                = 1'b1;
                wr_data           = {prio_live, prio_m, ent_id};
                res_d.result_slot = cmd_q.slot;
                res_d.found       = 1'b1;
                res_d.evicted_id  = prio_live ? '0 : ID_W'(ent_id);
              end
            end
            OP_FREE_SLOT: begin
              if (ent_valid) begin
                we                = 1'b1;
                wr_data           = {1'b0, ent_prio, ent_id};
                res_d.result_slot = cmd_q.slot;
                res_d.found       = 1'b1;
                res_d.evicted_id  = ID_W'(ent_id);
              end
            end
            OP_FREE_ID: begin
              if (match_hit_q) begin
                we                = 1'b1;
                wr_addr           = match_idx_q;
                wr_data           = {1'b0, {PRIO_BITS{1'b0}}, vid_m};
                res_d.result_slot = SLOT_W'(match_idx_q);
                res_d.found       = 1'b1;
                res_d.evicted_id  = ID_W'(vid_m);
              end
            end
            OP_REPLACE: begin
              if (match_hit_q) begin
                we                = 1'b1;
                wr_addr           = match_idx_q;
                wr_data           = {prio_live, prio_m, nid_m};
                res_d.result_slot = SLOT_W'(match_idx_q);
                res_d.found       = 1'b1;
                res_d.evicted_id  = ID_W'(vid_m);
              end
            end
            default: begin
              we = 1'b0;
            end
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // slot table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      iss_q       <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      dv_q    <= dv_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // scan accumulators: first empty, lowest priority, first id match
  always_ff @(posedge clk_i) begin
    didx_q <= iss_q;
    if (start) begin
      cmd_q       <= cmd_i;
      emp_hit_q   <= 1'b0;
      match_hit_q <= 1'b0;
    end else if (dv_q) begin
      if (!ent_valid && !emp_hit_q) begin
        emp_hit_q <= 1'b1;
        emp_idx_q <= didx_q;
      end
      if (didx_q == '0 || ent_prio < min_prio_q) begin
        min_prio_q <= ent_prio;
        min_idx_q  <= didx_q;
        min_id_q   <= ent_id;
      end
      if (ent_valid && ent_id == vid_m && !match_hit_q) begin
        match_hit_q <= 1'b1;
        match_idx_q <= didx_q;
      end
    end
    if (load) begin
      res_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_dv_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("scan data valid outside scan");

  a_steal_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && res_d.stolen) |-> (cmd_q.op == OP_ALLOC && !emp_hit_q))
    else $error("steal reported for a non-allocate or with an empty slot");

  a_out_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result raised outside execute");
`endif

endmodule

`default_nettype wire

// File: design/voice_slot_allocator_unit.sv
// Top level of the voice slot allocator.
`default_nettype none

// Voice slot allocator: a table of NUM_VOICES slots, each with a valid mark,
// a voice id and a priority. Items are allocate, set priority, free slot,
// free by id and replace id; each item gives exactly one result. The front
// end decodes an item and drops it into a two-entry command queue, so
// in_ready_o stays high while the back end is busy until two items wait in
// the queue. The back end runs one command at a time against a slot memory
// with one write port and one registered read port. Allocate, free by id and
// replace read every slot once, one slot per cycle, then pass a drain state
// before they execute; set priority and free slot read their one slot and
// then execute, and unknown kinds and slot indexes past the table go straight
// to execute. A result sits in an output register while the next command is
// worked on. After reset the back end sweeps the table empty, one slot per
// cycle, before it starts a command; items are still taken into the queue
// during that sweep.
module voice_slot_allocator_unit import vsa_pkg::*; #(
  parameter int NUM_VOICES = 128,
  parameter int ID_BITS    = 16,
  parameter int PRIO_BITS  = 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [SLOT_W-1:0] slot_i,
  input  wire logic [ID_W-1:0]   voice_id_i,
  input  wire logic [ID_W-1:0]   new_voice_id_i,
  input  wire logic [PRIO_W-1:0] priority_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [SLOT_W-1:0]      result_slot_o,
  output logic                   found_o,
  output logic                   stolen_o,
  output logic [ID_W-1:0]        evicted_id_o
);

  logic     cmd_valid;
  logic     cmd_ready;
  vsa_cmd_t cmd;
  vsa_res_t res;

  // decode and queue
  vsa_front #(
    .NUM_VOICES (NUM_VOICES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .slot_i         (slot_i),
    .voice_id_i     (voice_id_i),
    .new_voice_id_i (new_voice_id_i),
    .priority_req_i (priority_req_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_ready_i    (cmd_ready)
  );

  // table scan and update
  vsa_back #(
    .NUM_VOICES (NUM_VOICES),
    .ID_BITS    (ID_BITS),
    .PRIO_BITS  (PRIO_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign result_slot_o = res.result_slot;
  assign found_o       = res.found;
  assign stolen_o      = res.stolen;
  assign evicted_id_o  = res.evicted_id;

endmodule

`default_nettype wire

// File: tb/tb_voice_slot_allocator_unit.sv
// Testbench for voice_slot_allocator_unit: directed and random items against a slot table model.
`timescale 1ns / 1ps

module tb_voice_slot_allocator_unit import vsa_pkg::*;;

  localparam int VOICES      = 128;
  localparam int STALL_LIMIT = 4000;  // cycles with no item moving on either side
  localparam int MAX_REPORTS = 10;

  localparam logic [KIND_W-1:0] KIND_MAX  = '1;  // top of the unused kind codes
  localparam logic [PRIO_W-1:0] DEAD_PRIO = '0;
  localparam logic [PRIO_W-1:0] PRIO_MAX  = '1;
  localparam logic [ID_W-1:0]   ID_MAX    = '1;
  localparam logic [SLOT_W-1:0] SLOT_MAX  = '1;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [KIND_W-1:0] kind_i         = '0;
  logic [SLOT_W-1:0] slot_i         = '0;
  logic [ID_W-1:0]   voice_id_i     = '0;
  logic [ID_W-1:0]   new_voice_id_i = '0;
  logic [PRIO_W-1:0] priority_req_i = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [SLOT_W-1:0] result_slot_o;
  logic              found_o;
  logic              stolen_o;
  logic [ID_W-1:0]   evicted_id_o;

  // Model of the slot table; changes at the edge where an item is taken.
  logic              voice_busy [VOICES] = '{default: 1'b0};
  logic [ID_W-1:0]   voice_ids  [VOICES] = '{default: '0};
  logic [PRIO_W-1:0] voice_prios[VOICES] = '{default: '0};

  vsa_res_t    slot_result_q[$];  // results owed by the block, oldest first
  vsa_res_t    want_res;
  vsa_res_t    seen_res;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  bit          quiet_mode     = 1'b0;  // no idling on either side while set

  voice_slot_allocator_unit #(
    .NUM_VOICES(VOICES),
    .ID_BITS   (ID_W),
    .PRIO_BITS (PRIO_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .slot_i        (slot_i),
    .voice_id_i    (voice_id_i),
    .new_voice_id_i(new_voice_id_i),
    .priority_req_i(priority_req_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_slot_o (result_slot_o),
    .found_o       (found_o),
    .stolen_o      (stolen_o),
    .evicted_id_o  (evicted_id_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Lowest-index busy slot holding this id, or -1.
  function automatic int find_voice(logic [ID_W-1:0] id);
    for (int i = 0; i < VOICES; i++) begin
      if (voice_busy[i] && voice_ids[i] == id) return i;
    end
    return -1;
  endfunction

  // Applies one item to the table model and returns the result it owes.
  function automatic vsa_res_t apply_voice_cmd(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                               logic [ID_W-1:0] vid, logic [ID_W-1:0] nid,
                                               logic [PRIO_W-1:0] prio);
    vsa_res_t res;
    int       hit;
    res = '0;
    hit = -1;
    case (kind)
      KIND_ALLOC: begin
        for (int i = 0; i < VOICES; i++) begin
          if (!voice_busy[i]) begin
            hit = i;
            break;
          end
        end
        // Table full: lowest priority loses, strict compare keeps the lowest index on ties
        if (hit < 0) begin
          hit = 0;
          for (int i = 1; i < VOICES; i++) begin
            if (voice_prios[i] < voice_prios[hit]) hit = i;
          end
          res.stolen     = 1'b1;
          res.evicted_id = voice_ids[hit];
        end
        voice_ids[hit]   = nid;
        voice_prios[hit] = prio;
        voice_busy[hit]  = (prio != DEAD_PRIO);
        res.result_slot  = hit[SLOT_W-1:0];
        res.found        = 1'b1;
      end
      KIND_SET_PRIO: begin
        if (int'(slot) < VOICES && voice_busy[slot]) begin
          voice_prios[slot] = prio;
          if (prio == DEAD_PRIO) begin
            voice_busy[slot] = 1'b0;
            res.evicted_id   = voice_ids[slot];
          end
          res.result_slot = slot;
          res.found       = 1'b1;
        end
      end
      KIND_FREE_SLOT: begin
        if (int'(slot) < VOICES && voice_busy[slot]) begin
          voice_busy[slot] = 1'b0;
          res.result_slot  = slot;
          res.found        = 1'b1;
          res.evicted_id   = voice_ids[slot];
        end
      end
      KIND_FREE_ID: begin
        hit = find_voice(vid);
        if (hit >= 0) begin
          voice_busy[hit] = 1'b0;
          res.result_slot = hit[SLOT_W-1:0];
          res.found       = 1'b1;
          res.evicted_id  = voice_ids[hit];
        end
      end
      KIND_REPLACE: begin
        hit = find_voice(vid);
        if (hit >= 0) begin
          res.evicted_id   = voice_ids[hit];
          voice_ids[hit]   = nid;
          voice_prios[hit] = prio;
          voice_busy[hit]  = (prio != DEAD_PRIO);
          res.result_slot  = hit[SLOT_W-1:0];
          res.found        = 1'b1;
        end
      end
      default: ;  // unused kinds: no change, all zeros
    endcase
    return res;
  endfunction

  // Random busy slot, or any slot when the table is empty.
  function automatic int random_busy_slot();
    int busy_list[$];
    for (int i = 0; i < VOICES; i++) begin
      if (voice_busy[i]) busy_list = {busy_list, i};
    end
    if (busy_list.size() == 0) return int'($urandom_range(0, VOICES - 1));
    return busy_list[$urandom_range(0, busy_list.size() - 1)];
  endfunction

  task automatic report_bad(string why, vsa_res_t want, vsa_res_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t %s: want slot=%0d found=%0b stolen=%0b evicted=%h", $realtime, why,
               want.result_slot, want.found, want.stolen, want.evicted_id);
      $display("%0t %s:  got slot=%0d found=%0b stolen=%0b evicted=%h", $realtime, why,
               got.result_slot, got.found, got.stolen, got.evicted_id);
    end
  endtask

  // Result side: random back-pressure, decided at the falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= quiet_mode || ($urandom_range(0, 99) >= 33);
  end

  // One process both checks results and predicts taken items, so the
  // order of the two cannot matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen_res = '{result_slot: result_slot_o, found: found_o, stolen: stolen_o,
                     evicted_id: evicted_id_o};
        if (slot_result_q.size() == 0) begin
          report_bad("result with none owed", '0, seen_res);
        end else begin
          want_res = slot_result_q.pop_front();
          if (seen_res.result_slot !== want_res.result_slot ||
              seen_res.found       !== want_res.found ||
              seen_res.stolen      !== want_res.stolen ||
              seen_res.evicted_id  !== want_res.evicted_id) begin
            report_bad("result mismatch", want_res, seen_res);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        want_res = apply_voice_cmd(kind_i, slot_i, voice_id_i, new_voice_id_i, priority_req_i);
        slot_result_q = {slot_result_q, want_res};
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sends one item. Called at a falling edge, returns at a falling edge with
  // valid still high so the next call can keep it up without a glitch.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                           logic [ID_W-1:0] vid, logic [ID_W-1:0] nid,
                           logic [PRIO_W-1:0] prio);
    while (!quiet_mode && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    slot_i         <= slot;
    voice_id_i     <= vid;
    new_voice_id_i <= nid;
    priority_req_i <= prio;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (slot_result_q.size() != 0) @(negedge clk_i);
  endtask

  // Extremes of each field, every kind, and the corner cases on a near-empty table.
  task automatic test_directed();
    send_item(KIND_ALLOC,     '0,       '0,     ID_MAX,      PRIO_MAX);   // slot 0
    send_item(KIND_ALLOC,     '0,       '0,     '0,          DEAD_PRIO);  // slot 1, stays empty
    send_item(KIND_ALLOC,     SLOT_MAX, ID_MAX, 16'h1234,    3'd1);       // slot 1
    send_item(KIND_ALLOC,     '0,       '0,     16'h1234,    3'd3);       // same id in slot 2
    send_item(KIND_SET_PRIO,  SLOT_MAX, '0,     '0,          PRIO_MAX);   // empty slot
    send_item(KIND_SET_PRIO,  '0,       '0,     '0,          3'd1);
    send_item(KIND_SET_PRIO,  '0,       '0,     '0,          DEAD_PRIO);  // frees slot 0
    send_item(KIND_FREE_SLOT, '0,       '0,     '0,          '0);         // already empty
    send_item(KIND_FREE_ID,   '0,       16'h1234, '0,        '0);         // lowest of two
    send_item(KIND_REPLACE,   '0,       16'hBEEF, 16'h0042,  3'd2);       // not found
    send_item(KIND_REPLACE,   '0,       16'h1234, ID_MAX,    PRIO_MAX);
    send_item(KIND_REPLACE,   '0,       ID_MAX,   16'h0001,  DEAD_PRIO);  // replace to dead
    send_item(KIND_FREE_SLOT, SLOT_MAX, ID_MAX,   ID_MAX,    PRIO_MAX);
    send_item(KIND_FREE_ID,   SLOT_MAX, ID_MAX,   ID_MAX,    PRIO_MAX);   // not found
    send_item(KIND_ALLOC,     '0,       '0,       16'hAAAA,  PRIO_MAX);
    send_item(KIND_FREE_SLOT, '0,       '0,       '0,        '0);
    send_item(KIND_REPLACE + 3'd1, SLOT_MAX, ID_MAX, ID_MAX, PRIO_MAX);
    send_item(KIND_MAX - 3'd1, '0,      '0,       '0,        '0);
    send_item(KIND_MAX,       SLOT_MAX, ID_MAX,   ID_MAX,    PRIO_MAX);
    send_item(KIND_ALLOC,     '0,       '0,       '0,        PRIO_MAX);  // id zero stored
    send_item(KIND_FREE_ID,   '0,       '0,       '0,        '0);
  endtask

  // Fills the table, then steals: priority ties, a dead-priority steal, refill.
  task automatic test_table_full();
    int free_slots;
    free_slots = 0;
    for (int i = 0; i < VOICES; i++) begin
      if (!voice_busy[i]) free_slots++;
    end
    for (int i = 0; i < free_slots; i++) begin
      send_item(KIND_ALLOC, SLOT_W'($urandom), ID_W'($urandom),
                ID_W'($urandom_range(0, 63)), PRIO_W'($urandom_range(2, PRIO_MAX)));
    end
    send_item(KIND_ALLOC, '0, '0, 16'h5555, 3'd5);
    send_item(KIND_SET_PRIO, 7'd9, '0, '0, 3'd1);
    send_item(KIND_SET_PRIO, 7'd40, '0, '0, 3'd1);
    send_item(KIND_SET_PRIO, 7'd100, '0, '0, 3'd1);
    send_item(KIND_ALLOC, '0, '0, 16'h0909, PRIO_MAX);   // lowest index of the tie
    send_item(KIND_ALLOC, '0, '0, 16'h4040, DEAD_PRIO);  // steal, slot left empty
    send_item(KIND_ALLOC, '0, '0, 16'h4141, PRIO_MAX);   // takes the hole, no steal
    send_item(KIND_ALLOC, '0, '0, 16'h6464, PRIO_MAX);
    send_item(KIND_ALLOC, '0, '0, 16'h7777, 3'd2);
  endtask

  // Random mix; mostly items aimed at live slots and ids, some noise.
  task automatic test_random_mix(int unsigned n_items, int unsigned alloc_pct);
    int unsigned       roll;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   vid;
    logic [ID_W-1:0]   nid;
    logic [PRIO_W-1:0] prio;
    for (int unsigned k = 0; k < n_items; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        kind = KIND_ALLOC;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 20)      kind = KIND_SET_PRIO;
        else if (roll < 40) kind = KIND_FREE_SLOT;
        else if (roll < 65) kind = KIND_FREE_ID;
        else if (roll < 92) kind = KIND_REPLACE;
        else                kind = KIND_W'($urandom_range(KIND_REPLACE + 1, KIND_MAX));
      end
      slot = SLOT_W'(($urandom_range(0, 99) < 85) ? random_busy_slot() : int'($urandom));
      if ($urandom_range(0, 99) < 85)     vid = voice_ids[random_busy_slot()];
      else if ($urandom_range(0, 1) != 0) vid = ID_W'($urandom_range(0, 15));
      else                                vid = ID_W'($urandom);
      // small id pool makes duplicate ids common
      nid  = ID_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : $urandom);
      prio = ($urandom_range(0, 99) < 12) ? DEAD_PRIO : PRIO_W'($urandom_range(1, PRIO_MAX));
      send_item(kind, slot, vid, nid, prio);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    wait_for_results();
    test_table_full();
    test_random_mix(200, 35);   // table starts full: steals are common
    wait_for_results();
    quiet_mode = 1'b1;          // back-to-back stretch, no idling either side
    test_random_mix(120, 45);
    quiet_mode = 1'b0;
    test_random_mix(130, 20);   // frees dominate: table drains toward empty

    // drain, then give a stray result time to show up
    wait_for_results();
    repeat (VOICES + 20) @(posedge clk_i);
    if (mismatch_count == 0 && slot_result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
